### src/sptt_pkg.sv
// Shared types, codes and a helper function of the sparse polynomial term table.
package sptt_pkg;

  // Default table depth.
  localparam int unsigned MAX_TERMS_DEF = 32;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned PWR_W  = 16;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned DLT_W  = COEF_W + 1;
  localparam int unsigned SUM_W  = COEF_W + 2;
  localparam int unsigned TCNT_W = 6;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned MODE_W = 3;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_SET   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOCHG  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  // Update modes broadcast to the cells.
  localparam logic [MODE_W-1:0] MD_NONE   = 3'd0;
  localparam logic [MODE_W-1:0] MD_WRITE  = 3'd1;
  localparam logic [MODE_W-1:0] MD_DROP   = 3'd2;
  localparam logic [MODE_W-1:0] MD_INSERT = 3'd3;
  localparam logic [MODE_W-1:0] MD_CLEAR  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [PWR_W-1:0]  term_power;
    logic signed [COEF_W-1:0] coeff_value;
  } cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] read_coeff;
    logic signed [PWR_W-1:0]  degree;
    logic [TCNT_W-1:0]        term_count;
    logic [STAT_W-1:0]        status;
  } res_t;

  // One table entry as seen by the neighbors.
  typedef struct packed {
    logic                     vld;
    logic signed [PWR_W-1:0]  pw;
    logic signed [COEF_W-1:0] cf;
  } entry_t;

  // Word broadcast from the controller to every cell.
  typedef struct packed {
    logic                     cmp_en;
    logic                     is_set;
    logic signed [PWR_W-1:0]  pwr;
    logic signed [DLT_W-1:0]  dlt;
    logic [MODE_W-1:0]        mode;
    entry_t                   ins;
  } bcast_t;

  // Compare results each cell hands back; payloads are zero unless the cell matched.
  typedef struct packed {
    logic                     gt;
    logic                     eq;
    logic                     kill;
    logic signed [COEF_W-1:0] res_m;
    logic signed [COEF_W-1:0] cf_m;
  } flag_t;

  // Saturate a widened sum to the Q16.16 range.
  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(34'sd2147483647);
    lo = -SUM_W'(34'sd2147483648);
    if (v > hi) begin
      return hi[COEF_W-1:0];
    end else if (v < lo) begin
      return lo[COEF_W-1:0];
    end else begin
      return v[COEF_W-1:0];
    end
  endfunction

endpackage

### src/sptt_cell.sv
// One cell of the term chain: holds a single term, compares it and shifts with its neighbors.
module sptt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sptt_pkg::bcast_t bc_i,
  input  logic             prev_gt_i,
  input  sptt_pkg::entry_t prev_ent_i,
  input  sptt_pkg::entry_t next_ent_i,
  output sptt_pkg::entry_t ent_o,
  output sptt_pkg::flag_t  flag_o
);
  import sptt_pkg::*;

  logic                     vld_q, vld_d;
  logic signed [PWR_W-1:0]  pw_q, pw_d;
  logic signed [COEF_W-1:0] cf_q, cf_d;
  logic                     gt_q, eq_q;
  logic signed [COEF_W-1:0] res_q;
  logic signed [SUM_W-1:0]  sum;

  assign sum = SUM_W'(cf_q) + SUM_W'(bc_i.dlt);

  // Compare phase: flags and the candidate new coefficient are kept for the update phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (bc_i.cmp_en) begin
      gt_q <= vld_q && (pw_q > bc_i.pwr);
      eq_q <= vld_q && (pw_q == bc_i.pwr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bc_i.cmp_en) begin
      res_q <= bc_i.is_set ? bc_i.dlt[COEF_W-1:0] : sat_coef(sum);
    end
  end

  always_comb begin
    vld_d = vld_q;
    pw_d  = pw_q;
    cf_d  = cf_q;
    case (bc_i.mode)
      MD_WRITE: begin
        if (eq_q) begin
          cf_d = res_q;
        end
      end
      MD_DROP: begin
        if (!gt_q) begin
          vld_d = next_ent_i.vld;
          pw_d  = next_ent_i.pw;
          cf_d  = next_ent_i.cf;
        end
      end
      MD_INSERT: begin
        if (!gt_q) begin
          if (prev_gt_i) begin
            vld_d = bc_i.ins.vld;
            pw_d  = bc_i.ins.pw;
            cf_d  = bc_i.ins.cf;
          end else begin
            vld_d = prev_ent_i.vld;
            pw_d  = prev_ent_i.pw;
            cf_d  = prev_ent_i.cf;
          end
        end
      end
      MD_CLEAR: begin
        vld_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q <= pw_d;
    cf_q <= cf_d;
  end

  assign ent_o.vld    = vld_q;
  assign ent_o.pw     = pw_q;
  assign ent_o.cf     = cf_q;
  assign flag_o.gt    = gt_q;
  assign flag_o.eq    = eq_q;
  assign flag_o.kill  = eq_q && (res_q == '0);
  assign flag_o.res_m = eq_q ? res_q : '0;
  assign flag_o.cf_m  = eq_q ? cf_q : '0;

endmodule

### src/sparse_polynomial_term_table_core.sv
// Top level of the sparse polynomial term table: controller and chain of term cells.
//
// The block keeps one sparse polynomial as up to MAX_TERMS nonzero terms in a chain of
// cells, sorted by descending power, each cell holding one power and one Q16.16
// coefficient. A command word is accepted at a rising edge with start_i high and busy_o
// low. The cycle after acceptance is the compare cycle: every cell compares its power to
// the addressed one at once and precomputes its saturated new coefficient, and busy_o is
// high. The next cycle is the update cycle: all cells shift, write or clear together, and
// a new command word may already be accepted at its end. The result word appears on
// result_o during the following cycle, marked by done_o for exactly that one cycle; it
// cannot be held off, so a receiver must take it then. A command therefore goes through
// the compare and update passes over the cell chain between acceptance and result.
// There is no clearing pass: all cells are empty right after reset.
module sparse_polynomial_term_table_core #(
  parameter int unsigned MAX_TERMS = sptt_pkg::MAX_TERMS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sptt_pkg::cmd_t cmd_i,
  output logic           busy_o,
  output logic           done_o,
  output sptt_pkg::res_t result_o
);
  import sptt_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [OP_W-1:0]          op_q;
  logic signed [PWR_W-1:0]  pwr_q;
  logic signed [DLT_W-1:0]  dlt_q;
  logic                     czero_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     done_q;
  logic signed [COEF_W-1:0] rc_q, rc_d;
  logic [STAT_W-1:0]        st_q, st_d;
  logic                     accept;
  logic [MODE_W-1:0]        mode;
  logic signed [DLT_W-1:0]  dlt_in;
  logic signed [COEF_W-1:0] ins_cf;

  entry_t                   ent   [MAX_TERMS];
  flag_t                    flag  [MAX_TERMS];
  bcast_t                   bc;

  logic                     found;
  logic                     kill;
  logic signed [COEF_W-1:0] mres;
  logic signed [COEF_W-1:0] mcf;
  logic [CNT_W+TCNT_W-1:0]  cnt_ext;

  // A new word may enter while the previous one is in its update cycle.
  assign busy_o = (state_q == S_CMP);
  assign accept = start_i && !busy_o;

  // Operand for the cells: the coefficient itself for set and add, its negation for subtract.
  assign dlt_in = (cmd_i.opcode == OP_SUB) ? -DLT_W'(cmd_i.coeff_value)
                                           : DLT_W'(cmd_i.coeff_value);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  state_d = accept ? S_CMP : S_IDLE;
      S_CMP:   state_d = S_UPD;
      S_UPD:   state_d = accept ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == S_UPD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= cmd_i.opcode;
      pwr_q   <= cmd_i.term_power;
      dlt_q   <= dlt_in;
      czero_q <= (cmd_i.coeff_value == '0);
    end
    if (state_q == S_UPD) begin
      rc_q <= rc_d;
      st_q <= st_d;
    end
  end

  // Gather the matching cell's information; at most one cell matches.
  always_comb begin
    found = 1'b0;
    kill  = 1'b0;
    mres  = '0;
    mcf   = '0;
    for (int k = 0; k < MAX_TERMS; k++) begin
      found = found | flag[k].eq;
      kill  = kill | flag[k].kill;
      mres  = mres | flag[k].res_m;
      mcf   = mcf | flag[k].cf_m;
    end
  end

  assign ins_cf = sat_coef(SUM_W'(dlt_q));

  // Decide the update of the table and the result word.
  always_comb begin
    mode    = MD_NONE;
    count_d = count_q;
    rc_d    = '0;
    st_d    = STAT_DONE;
    if (state_q == S_UPD) begin
      if (op_q inside {OP_SET, OP_ADD, OP_SUB}) begin
        if (found) begin
          // A result of zero removes the term; otherwise it is written in place.
          rc_d = mres;
          if (kill) begin
            mode    = MD_DROP;
            count_d = count_q - CNT_W'(1);
          end else begin
            mode = MD_WRITE;
          end
        end else if (czero_q) begin
          st_d = STAT_NOCHG;
        end else if (count_q >= CNT_MAX) begin
          st_d = STAT_FULL;
        end else begin
          mode    = MD_INSERT;
          count_d = count_q + CNT_W'(1);
          rc_d    = ins_cf;
        end
      end else if (op_q == OP_CLEAR) begin
        mode    = MD_CLEAR;
        count_d = '0;
      end else begin
        // Read, and the unused opcodes, which behave as read.
        rc_d = found ? mcf : '0;
      end
    end
  end

  assign bc.cmp_en  = (state_q == S_CMP);
  assign bc.is_set  = (op_q == OP_SET);
  assign bc.pwr     = pwr_q;
  assign bc.dlt     = dlt_q;
  assign bc.mode    = mode;
  assign bc.ins.vld = 1'b1;
  assign bc.ins.pw  = pwr_q;
  assign bc.ins.cf  = ins_cf;

  // The chain: each cell sees the entries of both neighbors and the compare flag of the one
  // above it. The head cell treats the missing cell above as greater; the tail cell pulls in
  // an empty entry when the table closes up.
  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_gt;

    if (g == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_gt  = 1'b1;
    end else begin : g_body
      assign prev_ent = ent[g-1];
      assign prev_gt  = flag[g-1].gt;
    end

    if (g == MAX_TERMS - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[g+1];
    end

    sptt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .bc_i       (bc),
      .prev_gt_i  (prev_gt),
      .prev_ent_i (prev_ent),
      .next_ent_i (next_ent),
      .ent_o      (ent[g]),
      .flag_o     (flag[g])
    );
  end

  // The count field carries the low bits of the held count.
  assign cnt_ext = {{TCNT_W{1'b0}}, count_q};

  assign done_o              = done_q;
  assign result_o.read_coeff = rc_q;
  assign result_o.degree     = ent[0].vld ? ent[0].pw : '0;
  assign result_o.term_count = cnt_ext[TCNT_W-1:0];
  assign result_o.status     = st_q;

endmodule

### verif/sptt_term_checker.sv
// Checker for the sparse polynomial term table: keeps its own term list and compares results.
module sptt_term_checker
  import sptt_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  input  logic busy_i,
  input  logic done_i,
  input  res_t result_i,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output int   refused_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the term list, descending power, no zero coefficients.
  logic signed [PWR_W-1:0]  shadow_pw [MAX_TERMS];
  logic signed [COEF_W-1:0] shadow_cf [MAX_TERMS];
  int unsigned              shadow_held = 0;

  res_t coeff_reports_q [$];
  int   n_fail    = 0;
  int   n_checked = 0;
  int   n_refused = 0;

  function automatic logic signed [COEF_W-1:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[COEF_W-1:0];
  endfunction

  // Index of the first held term whose power is not above p.
  function automatic int unsigned slot_for(input logic signed [PWR_W-1:0] p);
    int unsigned i;
    i = 0;
    while (i < shadow_held && shadow_pw[i] > p) i++;
    return i;
  endfunction

  function automatic void remove_term(input int unsigned i);
    for (int unsigned k = i; k + 1 < shadow_held; k++) begin
      shadow_pw[k] = shadow_pw[k+1];
      shadow_cf[k] = shadow_cf[k+1];
    end
    if (shadow_held > 0) shadow_held--;
  endfunction

  function automatic logic [STAT_W-1:0] insert_term(input int unsigned i,
                                                    input logic signed [PWR_W-1:0] p,
                                                    input logic signed [COEF_W-1:0] c);
    if (shadow_held >= MAX_TERMS) return STAT_FULL;
    for (int unsigned k = shadow_held; k > i; k--) begin
      shadow_pw[k] = shadow_pw[k-1];
      shadow_cf[k] = shadow_cf[k-1];
    end
    shadow_pw[i] = p;
    shadow_cf[i] = c;
    shadow_held++;
    return STAT_DONE;
  endfunction

  // Merge delta into the term at p; a term that sums to zero disappears.
  function automatic logic [STAT_W-1:0] merge_term(input logic signed [PWR_W-1:0] p,
                                                   input longint delta);
    int unsigned                i;
    logic signed [COEF_W-1:0]   sum;
    i = slot_for(p);
    if (i < shadow_held && shadow_pw[i] == p) begin
      sum = clamp_q16(longint'(shadow_cf[i]) + delta);
      if (sum == 0) remove_term(i);
      else shadow_cf[i] = sum;
      return STAT_DONE;
    end
    if (delta == 0) return STAT_NOCHG;
    return insert_term(i, p, clamp_q16(delta));
  endfunction

  function automatic res_t apply_term_op(input cmd_t w);
    res_t                     r;
    int unsigned              i;
    logic signed [PWR_W-1:0]  p;
    logic signed [COEF_W-1:0] c;
    p = w.term_power;
    c = w.coeff_value;
    r = '0;
    r.status = STAT_DONE;
    case (w.opcode)
      OP_SET: begin
        i = slot_for(p);
        if (i < shadow_held && shadow_pw[i] == p) begin
          if (c == 0) remove_term(i);
          else shadow_cf[i] = c;
        end else if (c == 0) begin
          r.status = STAT_NOCHG;
        end else begin
          r.status = insert_term(i, p, c);
        end
      end
      OP_ADD:   r.status = merge_term(p, longint'(c));
      OP_SUB:   r.status = merge_term(p, -longint'(c));
      OP_CLEAR: shadow_held = 0;
      default: ;
    endcase
    i = slot_for(p);
    if (i < shadow_held && shadow_pw[i] == p) r.read_coeff = shadow_cf[i];
    if (shadow_held > 0) r.degree = shadow_pw[0];
    r.term_count = shadow_held[TCNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      shadow_held = 0;
      coeff_reports_q.delete();
    end else begin
      if (done_i) begin
        if (coeff_reports_q.size() == 0) begin
          n_fail++;
          $display("%0t: result word with nothing expected, actual %h", $time, result_i);
        end else begin
          want = coeff_reports_q.pop_front();
          n_checked++;
          if (want.status == STAT_FULL) n_refused++;
          check_field("read_coeff", want.read_coeff, result_i.read_coeff);
          check_field("degree", want.degree, result_i.degree);
          check_field("term_count", want.term_count, result_i.term_count);
          check_field("status", want.status, result_i.status);
        end
      end
      if (start_i && !busy_i) coeff_reports_q.push_back(apply_term_op(cmd_i));
    end
    fail_cnt_o <= n_fail;
    pending_o  <= coeff_reports_q.size();
    checked_o  <= n_checked;
    refused_o  <= n_refused;
  end

endmodule

### verif/tb_top.sv
// Testbench top of the sparse polynomial term table: stimulus, checker hookup and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sptt_pkg::*;

  // Table depth shared by the block and the checker.
  localparam int unsigned TERMS = MAX_TERMS_DEF;
  // Number of random command words after the directed part.
  localparam int RANDOM_WORDS = 1150;
  // Inserts in a fill burst; a few more than the table holds, so some get refused.
  localparam int FILL_WORDS = TERMS + 4;
  // Opcodes past clear, which the block treats as reads.
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;
  localparam logic signed [PWR_W-1:0]  PWR_MAX  = 16'sh7FFF;
  localparam logic signed [PWR_W-1:0]  PWR_MIN  = 16'sh8000;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i   = '0;
  logic busy_o;
  logic done_o;
  res_t result_o;

  int fail_cnt;
  int pending;
  int checked;
  int refused;

  // Stimulus bookkeeping: gap policy, words sent per opcode, and recently used powers
  // that later words aim at so that adds, subtracts and reads hit existing terms.
  bit                      no_gaps = 1'b0;
  int                      sent_per_op [8];
  int                      words_sent = 0;
  logic signed [PWR_W-1:0] recent_pw [$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sparse_polynomial_term_table_core #(
    .MAX_TERMS (TERMS)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // The checker watches both channels, keeps its own term list and counts failures.
  sptt_term_checker #(
    .MAX_TERMS (TERMS)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_i     (busy_o),
    .done_i     (done_o),
    .result_i   (result_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked),
    .refused_o  (refused)
  );

  function automatic cmd_t mk(input logic [OP_W-1:0] op, input logic signed [PWR_W-1:0] p,
                              input logic signed [COEF_W-1:0] c);
    cmd_t w;
    w.opcode      = op;
    w.term_power  = p;
    w.coeff_value = c;
    return w;
  endfunction

  // Present one word and hold it until the block takes it. The idle gap before the
  // word is drawn per word, so gaps land on the compare, update and result cycles
  // alike. start_i is lowered only when a gap is taken, so it is never lowered and
  // raised again in the same time step.
  task automatic send_word(input cmd_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= w;
    do @(posedge clk_i); while (busy_o);
    sent_per_op[w.opcode]++;
    words_sent++;
    if ((w.opcode == OP_SET || w.opcode == OP_ADD || w.opcode == OP_SUB) &&
        w.coeff_value != 0) begin
      recent_pw.push_back(w.term_power);
      if (recent_pw.size() > 64) void'(recent_pw.pop_front());
    end
  endtask

  // Stop sending and wait until every result word in flight has been checked.
  // The pending count is registered in the checker, so the value read here is the
  // settled one from the previous edge.
  task automatic hold_until_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // One random command word. Narrow phases keep the powers in a band of 48 values so
  // the table fills, cancels and reorders often; wide phases spread over the whole
  // 16-bit range. Small coefficients make add and subtract cancel terms to zero.
  function automatic cmd_t random_word(input bit narrow);
    cmd_t w;
    int   r;
    int   t;
    r = $urandom_range(0, 99);
    if (r < 30)      w.opcode = OP_SET;
    else if (r < 55) w.opcode = OP_ADD;
    else if (r < 75) w.opcode = OP_SUB;
    else if (r < 92) w.opcode = OP_READ;
    else if (r < 94) w.opcode = OP_CLEAR;
    else             w.opcode = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

    r = $urandom_range(0, 99);
    if (recent_pw.size() > 0 && r < 45) begin
      w.term_power = recent_pw[$urandom_range(0, recent_pw.size() - 1)];
    end else if (r < 50) begin
      w.term_power = $urandom_range(0, 1) ? PWR_MAX : PWR_MIN;
    end else if (narrow && r < 90) begin
      t = $urandom_range(0, 47);
      w.term_power = PWR_W'(t - 24);
    end else begin
      w.term_power = PWR_W'($urandom());
    end

    r = $urandom_range(0, 99);
    if (r < 10) begin
      w.coeff_value = '0;
    end else if (r < 40) begin
      t = $urandom_range(0, 6);
      w.coeff_value = COEF_W'(t - 3);
    end else if (r < 50) begin
      case ($urandom_range(0, 4))
        0:       w.coeff_value = COEF_MAX;
        1:       w.coeff_value = COEF_MIN;
        2:       w.coeff_value = 32'sd1;
        3:       w.coeff_value = -32'sd1;
        default: w.coeff_value = 32'sd65536;
      endcase
    end else begin
      w.coeff_value = COEF_W'($urandom());
    end
    return w;
  endfunction

  initial begin
    int  base;
    int  kind;
    int  len;
    bit  first_phase;
    foreach (sent_per_op[k]) sent_per_op[k] = 0;

    // Reset is held low at the start and released on a clock edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, zero operands on an absent term, both power and
    // coefficient extremes, saturation both ways including the negation of the most
    // negative coefficient, replace, removal by set and by cancellation, the spare
    // opcodes and clear.
    send_word(mk(OP_READ,  16'sd0,    32'sd0));
    send_word(mk(OP_SET,   16'sd5,    32'sd0));
    send_word(mk(OP_ADD,   16'sd5,    32'sd0));
    send_word(mk(OP_SUB,   16'sd5,    32'sd0));
    send_word(mk(OP_SET,   PWR_MAX,   COEF_MAX));
    send_word(mk(OP_SET,   PWR_MIN,   COEF_MIN));
    send_word(mk(OP_ADD,   PWR_MAX,   32'sd1));
    send_word(mk(OP_SUB,   PWR_MIN,   32'sd1));
    send_word(mk(OP_SUB,   16'sd100,  COEF_MIN));
    send_word(mk(OP_ADD,   16'sd100,  32'sd0));
    send_word(mk(OP_SET,   16'sd100,  32'sh00018000));
    send_word(mk(OP_ADD,   16'sd100,  -32'sh00018000));
    send_word(mk(OP_SET,   -16'sd1,   -32'sd65536));
    send_word(mk(OP_SET,   -16'sd1,   32'sd0));
    send_word(mk(OP_ADD,   16'sd7,    32'sh12345678));
    send_word(mk(OP_SUB,   16'sd7,    32'sh12345678));
    send_word(mk(OP_SPARE_LO,  PWR_MAX, COEF_MAX));
    send_word(mk(OP_SPARE_MID, PWR_MIN, COEF_MIN));
    send_word(mk(OP_SPARE_HI,  16'sd3,  32'sd9));
    send_word(mk(OP_READ,  PWR_MAX,   32'sd0));
    send_word(mk(OP_CLEAR, 16'sd0,    32'sd0));
    send_word(mk(OP_READ,  PWR_MAX,   32'sd0));
    send_word(mk(OP_ADD,   16'sd0,    -32'sd1));
    send_word(mk(OP_SET,   16'sd0,    COEF_MAX));

    // Let everything in flight finish before the random part starts.
    hold_until_drained();

    // Random part in phases. The first phase is a fill burst so the table is driven
    // full and inserts get refused early. Some phases run without idle gaps, and some
    // start by waiting until every result has come back.
    base        = words_sent;
    first_phase = 1'b1;
    while (words_sent - base < RANDOM_WORDS) begin
      kind = first_phase ? 0 : $urandom_range(0, 5);
      first_phase = 1'b0;
      if ($urandom_range(0, 3) == 0) hold_until_drained();
      no_gaps = ($urandom_range(0, 3) == 0);
      if (kind == 0) begin
        // Fill burst: empty the table, then insert more terms than it holds.
        send_word(mk(OP_CLEAR, PWR_W'($urandom()), COEF_W'($urandom())));
        repeat (FILL_WORDS)
          send_word(mk(OP_SET, PWR_W'($urandom()), COEF_W'($urandom() | 1)));
      end else begin
        len = $urandom_range(20, 120);
        repeat (len) send_word(random_word(kind <= 3));
      end
    end
    no_gaps = 1'b0;

    // Drain, then keep the clock running so that any stray result word can still show up.
    hold_until_drained();
    repeat (6) @(posedge clk_i);

    $display("Sent %0d words: %0d set, %0d add, %0d subtract, %0d read, %0d clear, %0d spare.",
             words_sent, sent_per_op[OP_SET], sent_per_op[OP_ADD], sent_per_op[OP_SUB],
             sent_per_op[OP_READ], sent_per_op[OP_CLEAR],
             sent_per_op[OP_SPARE_LO] + sent_per_op[OP_SPARE_MID] + sent_per_op[OP_SPARE_HI]);
    $display("Checked %0d result words, %0d of them inserts refused by a full table.",
             checked, refused);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
